>>> hw/rtl/trq_pkg.sv
// Package for the time-sorted request queue: entry type, codes and constants.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package trq_pkg;

  // Default number of cells in the queue
  localparam int unsigned QUEUE_DEPTH = 16;

  // Field widths; the minute of a 32-bit time reaches 71582788 and needs 27 bits
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MINUTE_W = 27;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned DEPT_W   = 16;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned OCC_W    = 5;

  // floor(t / 60) = floor((t >> 2) * MINUTE_MUL / 2^MINUTE_SHIFT) for any 32-bit t
  localparam logic [30:0] MINUTE_MUL   = 31'h4444_4445;
  localparam int unsigned MINUTE_SHIFT = 34;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TAKE   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOT_DUE = 2'd3
  } status_e;

  // One stored request, with its arrival minute kept alongside
  typedef struct packed {
    logic [TIME_W-1:0]   time_s;
    logic [MINUTE_W-1:0] minute;
    logic [PRIO_W-1:0]   prio;
    logic [DEPT_W-1:0]   dept;
    logic [ID_W-1:0]     req_id;
  } entry_t;

  // Commit controls broadcast to every cell
  typedef struct packed {
    logic ins;
    logic take;
  } cell_ctl_t;

endpackage : trq_pkg

`default_nettype wire

>>> hw/rtl/time_sorted_request_queue.sv
// Channel  | Direction | Handshake           | Beat contents
// command  | in        | start, busy         | operation, time_value, priority_req, department,
//          |           |                     | request_id
// result   | out       | done_o (one cycle)  | status, out_time, out_priority, out_department,
//          |           |                     | out_request_id, occupancy
//
// One command is taken each cycle; busy stays low, the queue never stalls.
// The minute of the time value is computed (one multiplier) and registered with the
// command; the operation is then committed on the row of cells and the result registered.
// Every cell compares with the new time at once, so insert and take each commit on the whole row.
// Reset empties the queue at once; cell contents are left as they are.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

module time_sorted_request_queue #(
  parameter int unsigned QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [trq_pkg::TIME_W-1:0]   time_value_i,
  input  logic [trq_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic [trq_pkg::DEPT_W-1:0]   department_i,
  input  logic [trq_pkg::ID_W-1:0]     request_id_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [trq_pkg::TIME_W-1:0]   out_time_o,
  output logic [trq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [trq_pkg::DEPT_W-1:0]   out_department_o,
  output logic [trq_pkg::ID_W-1:0]     out_request_id_o,
  output logic [trq_pkg::OCC_W-1:0]    occupancy_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                        accept;
  logic [trq_pkg::MINUTE_W-1:0] in_minute;

  logic                        s1_valid_q;
  trq_pkg::op_e                s1_op_q;
  trq_pkg::entry_t             s1_entry_q;

  logic [CNT_W-1:0]            count_q, count_d;
  logic                        empty, full, due;
  logic                        ins_go, take_go;
  trq_pkg::cell_ctl_t          ctl;
  trq_pkg::status_e            status_d;

  trq_pkg::entry_t             cell_entry [QUEUE_DEPTH];
  logic                        cell_place [QUEUE_DEPTH];

  logic                        done_q;
  trq_pkg::status_e            status_q;
  trq_pkg::entry_t             out_q, out_d;
  logic [CNT_W-1:0]            occ_q;
  logic [CNT_W+trq_pkg::OCC_W-1:0] occ_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Minute of the incoming time value
  trq_minute u_minute (
    .time_i   (time_value_i),
    .minute_o (in_minute)
  );

  // Hold the command and its minute for the commit cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q           <= trq_pkg::op_e'(operation_i);
      s1_entry_q.time_s <= time_value_i;
      s1_entry_q.minute <= in_minute;
      s1_entry_q.prio   <= priority_req_i;
      s1_entry_q.dept   <= department_i;
      s1_entry_q.req_id <= request_id_i;
    end
  end

  // Decide the operation against the head and the fill count
  assign empty   = (count_q == '0);
  assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign due     = (cell_entry[0].minute == s1_entry_q.minute);
  assign ins_go  = s1_valid_q && (s1_op_q == trq_pkg::OP_INSERT) && !full;
  assign take_go = s1_valid_q && (s1_op_q == trq_pkg::OP_TAKE) && !empty && due;
  assign ctl.ins  = ins_go;
  assign ctl.take = take_go;

  always_comb begin
    if (s1_op_q == trq_pkg::OP_INSERT) begin
      status_d = full ? trq_pkg::ST_FULL : trq_pkg::ST_OK;
    end else if (empty) begin
      status_d = trq_pkg::ST_EMPTY;
    end else begin
      status_d = due ? trq_pkg::ST_OK : trq_pkg::ST_NOT_DUE;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_go) begin
      count_d = count_q + 1'b1;
    end else if (take_go) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Row of cells, head at index zero
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic            valid;
    logic            prev_place;
    trq_pkg::entry_t prev_entry;
    trq_pkg::entry_t next_entry;

    assign valid = (count_q > CNT_W'(k));

    if (k == 0) begin : g_first
      assign prev_place = 1'b0;
      assign prev_entry = s1_entry_q;
    end else begin : g_mid
      assign prev_place = cell_place[k-1];
      assign prev_entry = cell_entry[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign next_entry = s1_entry_q;
    end else begin : g_inner
      assign next_entry = cell_entry[k+1];
    end

    trq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (valid),
      .prev_place_i (prev_place),
      .new_i        (s1_entry_q),
      .prev_i       (prev_entry),
      .next_i       (next_entry),
      .entry_o      (cell_entry[k]),
      .place_o      (cell_place[k])
    );
  end

  // Register the result beat; payload is zero unless the head leaves
  always_comb begin
    out_d = '0;
    if (take_go) begin
      out_d = cell_entry[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      status_q <= status_d;
      out_q    <= out_d;
      occ_q    <= count_d;
    end
  end

  assign occ_ext          = {{trq_pkg::OCC_W{1'b0}}, occ_q};
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_time_o       = out_q.time_s;
  assign out_priority_o   = out_q.prio;
  assign out_department_o = out_q.dept;
  assign out_request_id_o = out_q.req_id;
  assign occupancy_o      = occ_ext[trq_pkg::OCC_W-1:0];

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> done_q)
    else $error("committed command produced no result beat");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_entry[0].time_s <= cell_entry[1].time_s))
    else $error("head later than second entry");

  a_zero_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != trq_pkg::ST_OK) |-> (out_q == '0))
    else $error("failed command carries payload");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(count_q))
    else $error("count moved without a command");
`endif

endmodule : time_sorted_request_queue

`default_nettype wire

>>> hw/rtl/trq_minute.sv
// Minute of a 32-bit seconds value, floor(t / 60), by reciprocal multiplication.
// Depends on trq_pkg for widths and the reciprocal constant.
`default_nettype none

module trq_minute (
  input  logic [trq_pkg::TIME_W-1:0]   time_i,
  output logic [trq_pkg::MINUTE_W-1:0] minute_o
);

  logic [60:0] prod;

  // Divide by four with the shift, then by fifteen with the reciprocal
  assign prod     = {31'b0, time_i[31:2]} * {30'b0, trq_pkg::MINUTE_MUL};
  assign minute_o = prod[trq_pkg::MINUTE_SHIFT +: trq_pkg::MINUTE_W];

endmodule : trq_minute

`default_nettype wire

>>> hw/rtl/trq_cell.sv
// One cell of the sorted queue: holds an entry and trades it with its neighbours.
// Depends on trq_pkg for the entry and control types.
`default_nettype none

module trq_cell (
  input  logic                clk_i,
  input  trq_pkg::cell_ctl_t  ctl_i,
  input  logic                valid_i,
  input  logic                prev_place_i,
  input  trq_pkg::entry_t     new_i,
  input  trq_pkg::entry_t     prev_i,
  input  trq_pkg::entry_t     next_i,
  output trq_pkg::entry_t     entry_o,
  output logic                place_o
);

  trq_pkg::entry_t entry_q, entry_d;

  // New entry belongs at or before this cell: empty, or holding a later time
  assign place_o = !valid_i || (entry_q.time_s > new_i.time_s);

  // Shift up on insert behind the slot, load at the slot, shift down on take
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && place_o) begin
      entry_d = prev_place_i ? prev_i : new_i;
    end else if (ctl_i.take) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule : trq_cell

`default_nettype wire
